// ----- design/shell_line_token_counter_defines.svh -----
// Assertion macros shared by the token counter RTL files.
`ifndef SHELL_LINE_TOKEN_COUNTER_DEFINES_SVH
`define SHELL_LINE_TOKEN_COUNTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define SLT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("token counter check failed");
// Checked at every edge, reset included.
`define SLT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("token counter check failed");
`else
`define SLT_ASSERT(label, clk, rstn, prop)
`define SLT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- design/slt_pkg.sv -----
// Shared types, character codes and lexer helpers for the token counter.
`default_nettype none
package slt_pkg;

    localparam int MAX_COUNT_DEF = 4096;
    localparam int OUT_W         = 13;
    localparam int CHAR_W        = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PIPE  = 8'h7C;
    localparam logic [CHAR_W-1:0] CHAR_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CHAR_GT    = 8'h3E;
    localparam logic [CHAR_W-1:0] CHAR_DQ    = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQ    = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

    // Lexer modes, one-hot
    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_WORD = 6'b000010,
        MODE_LT   = 6'b000100,
        MODE_GT   = 6'b001000,
        MODE_DQ   = 6'b010000,
        MODE_SQ   = 6'b100000
    } mode_t;

    // Byte held in the input stage
    typedef struct packed {
        logic              vld;
        logic [CHAR_W-1:0] code;
    } byte_t;

    // Outcome of one lexer step from the idle position
    typedef struct packed {
        mode_t mode;
        logic  bump;
    } step_t;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return is_space(c) || (c == CHAR_PIPE) || (c == CHAR_LT) ||
               (c == CHAR_GT) || (c == CHAR_DQ) || (c == CHAR_SQ);
    endfunction

    // Byte handled as if no token were open
    function automatic step_t from_idle(input logic [CHAR_W-1:0] c);
        step_t s;
        s.mode = MODE_IDLE;
        s.bump = 1'b0;
        if (is_space(c)) begin
            s.mode = MODE_IDLE;
        end else if (c == CHAR_PIPE) begin
            s.bump = 1'b1;
        end else if (c == CHAR_LT) begin
            s.bump = 1'b1;
            s.mode = MODE_LT;
        end else if (c == CHAR_GT) begin
            s.bump = 1'b1;
            s.mode = MODE_GT;
        end else if (c == CHAR_DQ) begin
            s.mode = MODE_DQ;
        end else if (c == CHAR_SQ) begin
            s.mode = MODE_SQ;
        end else begin
            s.bump = 1'b1;
            s.mode = MODE_WORD;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- design/slt_in_stage.sv -----
// Input register: holds one byte until the lexer takes it.
`default_nettype none
module slt_in_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [slt_pkg::CHAR_W-1:0]  s_char_code,
    input  wire logic                        drain,
    output slt_pkg::byte_t                   held
);
    import slt_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    logic [CHAR_W-1:0] code_reg;

    // Free when empty or when the held byte moves on this cycle
    assign s_ready = !vld_reg || drain;

    always_comb begin
        vld_next = vld_reg;
        if (s_ready) begin
            vld_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            code_reg <= s_char_code;
        end
    end

    assign held.vld  = vld_reg;
    assign held.code = code_reg;

endmodule
`default_nettype wire

// ----- design/slt_lexer.sv -----
// Lexer state and token counter, one byte per step.
`default_nettype none
`include "shell_line_token_counter_defines.svh"
module slt_lexer #(
    parameter int MAX_COUNT = slt_pkg::MAX_COUNT_DEF,
    parameter int TOKEN_W   = $clog2(MAX_COUNT + 1)
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire slt_pkg::byte_t held,
    input  wire logic           step,
    output logic                line_done,
    output logic [TOKEN_W-1:0]  line_count
);
    import slt_pkg::*;

    localparam logic [TOKEN_W-1:0] CNT_MAX = TOKEN_W'(MAX_COUNT);
    localparam logic [TOKEN_W-1:0] CNT_ONE = TOKEN_W'(1);

    mode_t              mode_reg;
    mode_t              mode_next;
    logic [TOKEN_W-1:0] cnt_reg;
    logic [TOKEN_W-1:0] cnt_next;
    logic               ls_reg;
    logic               ls_next;
    logic               bump;
    logic               is_term;
    step_t              idle_step;

    assign is_term   = (held.code == CHAR_NUL);
    assign idle_step = from_idle(held.code);

    // Mode transition for a non-terminator byte
    always_comb begin
        mode_next = mode_reg;
        bump      = 1'b0;
        case (mode_reg)
            MODE_DQ: begin
                if (held.code == CHAR_DQ) begin
                    bump      = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_SQ: begin
                if (held.code == CHAR_SQ) begin
                    bump      = 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_LT: begin
                if (held.code == CHAR_LT) begin
                    mode_next = MODE_IDLE;
                end else begin
                    mode_next = idle_step.mode;
                    bump      = idle_step.bump;
                end
            end
            MODE_GT: begin
                if (held.code == CHAR_GT) begin
                    mode_next = MODE_IDLE;
                end else begin
                    mode_next = idle_step.mode;
                    bump      = idle_step.bump;
                end
            end
            MODE_WORD: begin
                if (is_delim(held.code)) begin
                    mode_next = idle_step.mode;
                    bump      = idle_step.bump;
                end
            end
            default: begin
                mode_next = idle_step.mode;
                bump      = idle_step.bump;
            end
        endcase
    end

    // Counter and line-start flag; terminator returns to start state
    always_comb begin
        cnt_next = cnt_reg;
        ls_next  = ls_reg;
        if (step) begin
            if (is_term) begin
                cnt_next = '0;
                ls_next  = 1'b1;
            end else begin
                ls_next = 1'b0;
                if (bump && (cnt_reg < CNT_MAX)) begin
                    cnt_next = cnt_reg + CNT_ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            ls_reg   <= 1'b1;
        end else begin
            cnt_reg <= cnt_next;
            ls_reg  <= ls_next;
            if (step) begin
                mode_reg <= is_term ? MODE_IDLE : mode_next;
            end
        end
    end

    // Result for the line that ends with this byte
    assign line_done  = step && is_term;
    assign line_count = ls_reg ? CNT_ONE : cnt_reg;

    `SLT_ASSERT(a_cnt_bounded, aclk, aresetn, cnt_reg <= CNT_MAX)
    `SLT_ASSERT(a_term_clears, aclk, aresetn,
        (step && is_term) |=> (cnt_reg == '0) && ls_reg && (mode_reg == MODE_IDLE))
    `SLT_ASSERT(a_byte_clears_start, aclk, aresetn, (step && !is_term) |=> !ls_reg)
    `SLT_ASSERT(a_quote_holds, aclk, aresetn,
        (step && !is_term && (mode_reg == MODE_DQ) && (held.code != CHAR_DQ))
            |=> $stable(cnt_reg))

endmodule
`default_nettype wire

// ----- design/slt_out_stage.sv -----
// Result register: holds a line's token count until it is taken.
`default_nettype none
`include "shell_line_token_counter_defines.svh"
module slt_out_stage #(
    parameter int TOKEN_W = 13
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       load,
    input  wire logic [TOKEN_W-1:0]         count,
    output logic                            free,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [slt_pkg::OUT_W-1:0]       m_token_count
);
    import slt_pkg::*;

    logic                   vld_reg;
    logic                   vld_next;
    logic [OUT_W-1:0]       data_reg;
    logic [TOKEN_W+OUT_W-1:0] count_ext;

    // Masked to the output width whatever the counter width is
    assign count_ext = {{OUT_W{1'b0}}, count};

    assign free = !vld_reg || m_ready;

    always_comb begin
        vld_next = vld_reg;
        if (free) begin
            vld_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= count_ext[OUT_W-1:0];
        end
    end

    assign m_valid       = vld_reg;
    assign m_token_count = data_reg;

    `SLT_ASSERT(a_load_shows, aclk, aresetn, (load && free) |=> vld_reg)
    `SLT_ASSERT(a_no_lost_load, aclk, aresetn, load |-> free)
    `SLT_ASSERT_ALWAYS(a_empty_after_reset, aclk, !aresetn |=> !vld_reg)

endmodule
`default_nettype wire

// ----- design/shell_line_token_counter.sv -----
// Token counter top level: input register, lexer step, result register.
// Result path: a terminator byte's count goes through the input register and then the
// result register to m_valid. Throughput: one byte per cycle; the lexer state update
// follows the input register; only a terminator waits when the result register is full.
// Reset: synchronous, active low; clears both stages and returns the lexer to line start.
`default_nettype none
module shell_line_token_counter #(
    parameter int MAX_COUNT = slt_pkg::MAX_COUNT_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [slt_pkg::CHAR_W-1:0]  s_char_code,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [slt_pkg::OUT_W-1:0]        m_token_count
);
    import slt_pkg::*;

    localparam int TOKEN_W = $clog2(MAX_COUNT + 1);

    byte_t              held;
    logic               drain;
    logic               step;
    logic               out_free;
    logic               line_done;
    logic [TOKEN_W-1:0] line_count;

    // A held byte moves on unless it ends a line and the result slot is full
    assign drain = (held.code != CHAR_NUL) || out_free;
    assign step  = held.vld && drain;

    slt_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .drain       (drain),
        .held        (held)
    );

    slt_lexer #(
        .MAX_COUNT (MAX_COUNT),
        .TOKEN_W   (TOKEN_W)
    ) u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .held       (held),
        .step       (step),
        .line_done  (line_done),
        .line_count (line_count)
    );

    slt_out_stage #(
        .TOKEN_W (TOKEN_W)
    ) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (line_done),
        .count         (line_count),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_count (m_token_count)
    );

endmodule
`default_nettype wire
